>>> hw/rtl/assert_macros.svh
// assert_macros.svh: assertion shorthands for the checker modules
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/rpn_pkg.sv
// rpn_pkg: types, constants and arithmetic helpers of the rpn stack calculator
// used by every module of the block; depends on nothing
package rpn_pkg;

  // sizes
  localparam int STACK_ENTRIES = 128;
  localparam int VALUE_BITS    = 32;
  localparam int FRAC_BITS     = VALUE_BITS / 2;
  localparam int CNT_BITS      = $clog2(STACK_ENTRIES + 1);
  localparam int IDX_BITS      = $clog2(STACK_ENTRIES);
  localparam int NUM_BITS      = VALUE_BITS + FRAC_BITS;
  localparam int PROD_BITS     = 2 * VALUE_BITS;
  localparam int DIV_STEP_BITS = 2;
  localparam int DIV_ITERS     = (NUM_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int DIV_BITS      = DIV_ITERS * DIV_STEP_BITS;
  localparam int ITER_BITS     = $clog2(DIV_ITERS + 1);
  localparam int OPERAND_BITS  = 32;
  localparam int TOP_BITS      = 32;
  localparam int DEPTH_BITS    = 8;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [VALUE_BITS-1:0]        mag_t;
  typedef logic [NUM_BITS-1:0]          wide_t;
  typedef logic [CNT_BITS-1:0]          count_t;
  typedef logic [IDX_BITS-1:0]          idx_t;

  localparam value_t VAL_MAX   = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam value_t VAL_MIN   = {1'b1, {(VALUE_BITS - 1){1'b0}}};
  localparam value_t ONE_VALUE =
    {{(VALUE_BITS - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // instruction codes
  typedef enum logic [3:0] {
    MODE_PUSH = 4'd0,
    MODE_ADD  = 4'd1,
    MODE_SUB  = 4'd2,
    MODE_MUL  = 4'd3,
    MODE_DIV  = 4'd4,
    MODE_EQ   = 4'd5,
    MODE_NE   = 4'd6,
    MODE_AND  = 4'd7,
    MODE_OR   = 4'd8,
    MODE_GT   = 4'd9,
    MODE_GE   = 4'd10,
    MODE_LT   = 4'd11,
    MODE_LE   = 4'd12,
    MODE_NOT  = 4'd13
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_FETCH,
    CS_DIVIDE,
    CS_COMMIT
  } ctrl_state_t;

  // channel payloads
  typedef struct packed {
    logic [3:0]                     mode;
    logic signed [OPERAND_BITS-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [TOP_BITS-1:0] top_value;
    logic [DEPTH_BITS-1:0]      stack_depth;
    status_t                    status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic    load_ins;
    logic    rd_a;
    logic    start_ops;
    logic    commit;
    status_t code;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] mode;
    logic       empty;
    logic       lt_two;
    logic       full;
    logic       b_zero;
    logic       div_done;
    logic       out_free;
  } ctrl_stat_t;

  // absolute value as an unsigned magnitude
  function automatic mag_t mag_of(input value_t v);
    return v[VALUE_BITS-1] ? mag_t'(0) - mag_t'(v) : mag_t'(v);
  endfunction

  // apply a sign to a wide magnitude and clamp to the value range
  function automatic value_t sat_mag(input logic neg, input wide_t m);
    mag_t lim;
    mag_t low;
    lim = neg ? mag_t'(VAL_MIN) : mag_t'(VAL_MAX);
    low = m[VALUE_BITS-1:0];
    if (m > NUM_BITS'(lim)) return neg ? VAL_MIN : VAL_MAX;
    return neg ? value_t'(mag_t'(0) - low) : value_t'(low);
  endfunction

  function automatic value_t sat_add(input value_t a, input value_t b);
    logic signed [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    return s[VALUE_BITS-1:0];
  endfunction

  function automatic value_t sat_sub(input value_t a, input value_t b);
    logic signed [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    return s[VALUE_BITS-1:0];
  endfunction

  // pushed operand into the value range
  function automatic value_t push_value(input logic signed [OPERAND_BITS-1:0] x);
    logic signed [64:0] wx;
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    wx = x;
    hi = VAL_MAX;
    lo = VAL_MIN;
    if (wx > hi) return VAL_MAX;
    if (wx < lo) return VAL_MIN;
    return value_t'(wx);
  endfunction

  // value onto the top_value field
  function automatic logic signed [TOP_BITS-1:0] to_top(input value_t v);
    logic signed [64:0] w;
    w = v;
    return w[TOP_BITS-1:0];
  endfunction

  function automatic value_t truth(input logic t);
    return t ? ONE_VALUE : '0;
  endfunction

endpackage

>>> hw/rtl/rpn_div.sv
// rpn_div: iterative unsigned divider for fixed point quotients, two bits a cycle
// depends on rpn_pkg
module rpn_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  rpn_pkg::mag_t   dividend,
  input  rpn_pkg::mag_t   divisor,
  output logic            done,
  output rpn_pkg::wide_t  quotient
);

  logic [rpn_pkg::DIV_BITS-1:0]   shift_r, shift_nxt;
  rpn_pkg::mag_t                  rem_r, rem_nxt;
  rpn_pkg::mag_t                  divisor_r;
  logic [rpn_pkg::ITER_BITS-1:0]  iter_r;
  logic                           busy_r;
  logic                           done_r;

  // restoring steps: numerator shifts out at the top, quotient bits enter at the bottom
  always_comb begin
    logic [rpn_pkg::VALUE_BITS:0] trial;
    logic [rpn_pkg::VALUE_BITS:0] diff;
    rem_nxt   = rem_r;
    shift_nxt = shift_r;
    for (int k = 0; k < rpn_pkg::DIV_STEP_BITS; k++) begin
      trial     = {rem_nxt, shift_nxt[rpn_pkg::DIV_BITS-1]};
      diff      = trial - {1'b0, divisor_r};
      shift_nxt = {shift_nxt[rpn_pkg::DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor_r}) begin
        rem_nxt      = diff[rpn_pkg::VALUE_BITS-1:0];
        shift_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[rpn_pkg::VALUE_BITS-1:0];
      end
    end
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      iter_r <= rpn_pkg::ITER_BITS'(rpn_pkg::DIV_ITERS);
    end else if (busy_r) begin
      iter_r <= iter_r - 1'b1;
      if (iter_r == rpn_pkg::ITER_BITS'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // numerator, remainder and divisor
  always_ff @(posedge clk) begin
    if (start) begin
      shift_r   <= rpn_pkg::DIV_BITS'({dividend, {rpn_pkg::FRAC_BITS{1'b0}}});
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = shift_r[rpn_pkg::NUM_BITS-1:0];

endmodule

>>> hw/rtl/rpn_ctrl.sv
// rpn_ctrl: controller state machine that sequences one instruction at a time
// depends on rpn_pkg; drives the datapath through ctrl_cmd_t
module rpn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpn_pkg::ctrl_stat_t stat,
  output rpn_pkg::ctrl_cmd_t  cmd
);

  rpn_pkg::ctrl_state_t state_r, state_nxt;
  rpn_pkg::status_t     code_r, code_nxt;
  logic                 is_binary;

  assign is_binary = stat.mode inside {[rpn_pkg::MODE_ADD:rpn_pkg::MODE_LE]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpn_pkg::CS_IDLE;
      code_r  <= rpn_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // next state and outcome code
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    case (state_r)
      rpn_pkg::CS_IDLE: begin
        if (in_valid) begin
          state_nxt = rpn_pkg::CS_DECODE;
          code_nxt  = rpn_pkg::ST_OK;
        end
      end
      rpn_pkg::CS_DECODE: begin
        state_nxt = rpn_pkg::CS_COMMIT;
        if (stat.mode == rpn_pkg::MODE_PUSH) begin
          if (stat.full) code_nxt = rpn_pkg::ST_OVER;
        end else if (stat.mode == rpn_pkg::MODE_NOT) begin
          if (stat.empty) code_nxt = rpn_pkg::ST_UNDER;
        end else if (is_binary) begin
          if (stat.lt_two) code_nxt = rpn_pkg::ST_UNDER;
          else state_nxt = rpn_pkg::CS_FETCH;
        end
      end
      rpn_pkg::CS_FETCH: begin
        state_nxt = rpn_pkg::CS_COMMIT;
        if (stat.mode == rpn_pkg::MODE_DIV) begin
          if (stat.b_zero) code_nxt = rpn_pkg::ST_DIVZ;
          else state_nxt = rpn_pkg::CS_DIVIDE;
        end
      end
      rpn_pkg::CS_DIVIDE: begin
        if (stat.div_done) state_nxt = rpn_pkg::CS_COMMIT;
      end
      rpn_pkg::CS_COMMIT: begin
        if (stat.out_free) state_nxt = rpn_pkg::CS_IDLE;
      end
      default: state_nxt = rpn_pkg::CS_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.code      = code_r;
    cmd.load_ins  = (state_r == rpn_pkg::CS_IDLE) && in_valid;
    cmd.rd_a      = (state_r == rpn_pkg::CS_DECODE) && is_binary && !stat.lt_two;
    cmd.start_ops = (state_r == rpn_pkg::CS_FETCH);
    cmd.commit    = (state_r == rpn_pkg::CS_COMMIT) && stat.out_free;
  end

  assign in_stall = (state_r != rpn_pkg::CS_IDLE);

endmodule

>>> hw/rtl/rpn_dpath.sv
// rpn_dpath: stack memory, top of stack register, operation units and result register
// depends on rpn_pkg and rpn_div; commanded by rpn_ctrl
module rpn_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  rpn_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rpn_pkg::out_item_t  out_data,
  input  rpn_pkg::ctrl_cmd_t  cmd,
  output rpn_pkg::ctrl_stat_t stat
);

  // entries below the top live in memory, the top lives in top_r
  rpn_pkg::value_t    stack_mem [rpn_pkg::STACK_ENTRIES];
  rpn_pkg::in_item_t  ins_r;
  rpn_pkg::value_t    top_r, top_nxt;
  rpn_pkg::count_t    count_r, count_nxt;
  rpn_pkg::value_t    rd_r;
  logic [rpn_pkg::PROD_BITS-1:0] prod_r;
  rpn_pkg::out_item_t out_r;
  logic               out_valid_r;

  rpn_pkg::count_t    count_m1, count_m2;
  rpn_pkg::idx_t      wr_idx, rd_idx;
  rpn_pkg::mag_t      a_mag, b_mag;
  logic               neg;
  logic               apply;
  logic               div_start;
  logic               div_done;
  rpn_pkg::wide_t     quotient;
  rpn_pkg::value_t    bin_res;

  assign count_m1 = count_r - rpn_pkg::CNT_BITS'(1);
  assign count_m2 = count_r - rpn_pkg::CNT_BITS'(2);
  assign wr_idx   = count_m1[rpn_pkg::IDX_BITS-1:0];
  assign rd_idx   = count_m2[rpn_pkg::IDX_BITS-1:0];

  // instruction register
  always_ff @(posedge clk) begin
    if (cmd.load_ins) ins_r <= in_data;
  end

  // stack memory: old top goes down on a push, second entry is read for binary ops
  always_ff @(posedge clk) begin
    if (cmd.commit && ins_r.mode == rpn_pkg::MODE_PUSH && apply && count_r != '0) begin
      stack_mem[wr_idx] <= top_r;
    end
    if (cmd.rd_a) rd_r <= stack_mem[rd_idx];
  end

  // magnitude product, truncated to the fraction bits at commit
  assign a_mag = rpn_pkg::mag_of(rd_r);
  assign b_mag = rpn_pkg::mag_of(top_r);
  assign neg   = rd_r[rpn_pkg::VALUE_BITS-1] ^ top_r[rpn_pkg::VALUE_BITS-1];

  always_ff @(posedge clk) begin
    if (cmd.start_ops) prod_r <= a_mag * b_mag;
  end

  assign div_start = cmd.start_ops && ins_r.mode == rpn_pkg::MODE_DIV && top_r != '0;

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a_mag),
    .divisor  (b_mag),
    .done     (div_done),
    .quotient (quotient)
  );

  // result of a binary operation, a below and b on top
  always_comb begin
    case (ins_r.mode)
      rpn_pkg::MODE_ADD: bin_res = rpn_pkg::sat_add(rd_r, top_r);
      rpn_pkg::MODE_SUB: bin_res = rpn_pkg::sat_sub(rd_r, top_r);
      rpn_pkg::MODE_MUL:
        bin_res = rpn_pkg::sat_mag(neg, prod_r[rpn_pkg::FRAC_BITS +: rpn_pkg::NUM_BITS]);
      rpn_pkg::MODE_DIV: begin
        if (top_r == '0) begin
          bin_res = rd_r[rpn_pkg::VALUE_BITS-1] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
        end else begin
          bin_res = rpn_pkg::sat_mag(neg, quotient);
        end
      end
      rpn_pkg::MODE_EQ:  bin_res = rpn_pkg::truth(rd_r == top_r);
      rpn_pkg::MODE_NE:  bin_res = rpn_pkg::truth(rd_r != top_r);
      rpn_pkg::MODE_AND: bin_res = rpn_pkg::truth(rd_r != '0 && top_r != '0);
      rpn_pkg::MODE_OR:  bin_res = rpn_pkg::truth(rd_r != '0 || top_r != '0);
      rpn_pkg::MODE_GT:  bin_res = rpn_pkg::truth(rd_r > top_r);
      rpn_pkg::MODE_GE:  bin_res = rpn_pkg::truth(rd_r >= top_r);
      rpn_pkg::MODE_LT:  bin_res = rpn_pkg::truth(rd_r < top_r);
      default:           bin_res = rpn_pkg::truth(rd_r <= top_r);
    endcase
  end

  // stack update on commit; underflow and overflow leave it alone
  assign apply = (cmd.code == rpn_pkg::ST_OK) || (cmd.code == rpn_pkg::ST_DIVZ);

  always_comb begin
    top_nxt   = top_r;
    count_nxt = count_r;
    if (apply) begin
      if (ins_r.mode == rpn_pkg::MODE_PUSH) begin
        top_nxt   = rpn_pkg::push_value(ins_r.operand_value);
        count_nxt = count_r + rpn_pkg::CNT_BITS'(1);
      end else if (ins_r.mode == rpn_pkg::MODE_NOT) begin
        top_nxt = rpn_pkg::truth(top_r == '0);
      end else if (ins_r.mode inside {[rpn_pkg::MODE_ADD:rpn_pkg::MODE_LE]}) begin
        top_nxt   = bin_res;
        count_nxt = count_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) top_r <= top_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.top_value   <= rpn_pkg::to_top(count_nxt != '0 ? top_nxt : '0);
      out_r.stack_depth <= rpn_pkg::DEPTH_BITS'(count_nxt);
      out_r.status      <= cmd.code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status toward the controller
  always_comb begin
    stat          = '0;
    stat.mode     = ins_r.mode;
    stat.empty    = (count_r == '0);
    stat.lt_two   = (count_r < rpn_pkg::CNT_BITS'(2));
    stat.full     = (count_r == rpn_pkg::CNT_BITS'(rpn_pkg::STACK_ENTRIES));
    stat.b_zero   = (top_r == '0);
    stat.div_done = div_done;
    stat.out_free = !out_valid_r || !out_stall;
  end

endmodule

>>> hw/rtl/rpn_stack_calculator.sv
// RPN stack calculator: takes one instruction per item (push, a two-operand
// arithmetic, compare or logic operation, or not) on signed Q16.16 values and
// returns one item with the new top, depth and status. The block works on one
// item at a time. After an item is accepted, a push, not, unused code or
// flagged underflow/overflow goes through DECODE and COMMIT. A two-operand
// operation, divide by zero included, passes DECODE, FETCH and COMMIT. A
// divide also waits in DIVIDE for the divider, which retires two quotient bits
// a cycle over the 48-bit numerator. The result register is loaded as COMMIT
// passes to IDLE, where the next item can be taken; a result held by out_stall
// delays that load. The stack top sits in a register and the entries below it
// in a single-port memory that is read once per two-operand operation; the
// memory needs no clearing after reset, so items are taken right away. A
// finished result waits in the output register while the next item is taken.
// depends on rpn_pkg, rpn_ctrl, rpn_dpath
module rpn_stack_calculator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rpn_pkg::out_item_t out_data
);

  rpn_pkg::ctrl_cmd_t  cmd;
  rpn_pkg::ctrl_stat_t stat;

  // sequencer
  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack and operation units
  rpn_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> hw/rtl/rpn_checker.sv
// rpn_checker: port level assertions for the rpn stack calculator, bound to the top
// depends on rpn_pkg and assert_macros.svh
`include "assert_macros.svh"

module rpn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input rpn_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input rpn_pkg::out_item_t out_data
);

  // one item at a time: after an item is taken the input side stalls
  `ASSERT_NEXT(a_stall_after_accept, in_valid && !in_stall, in_stall)

  // a stalled input item holds
  `ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // overflow only on a full stack
  `ASSERT_SAME(a_over_full, out_valid && out_data.status == rpn_pkg::ST_OVER,
    out_data.stack_depth == rpn_pkg::DEPTH_BITS'(rpn_pkg::STACK_ENTRIES))

  // underflow only with fewer than two entries
  `ASSERT_SAME(a_under_short, out_valid && out_data.status == rpn_pkg::ST_UNDER,
    out_data.stack_depth < rpn_pkg::DEPTH_BITS'(2))

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> bench/tb_rpn_stack_calculator.sv
`timescale 1ns / 100ps
// tb_rpn_stack_calculator: self-checking bench for the rpn stack calculator
// a shadow stack predicts every result item; depends on rpn_pkg and rpn_stack_calculator

module tb_rpn_stack_calculator;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 60;

  // codes above not: the block leaves the stack alone
  localparam logic [3:0] MODE_SPARE_LO = 4'd14;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;

  // handy Q16.16 values
  localparam rpn_pkg::value_t LSB_VALUE      = 32'sh0000_0001;
  localparam rpn_pkg::value_t NEG_LSB_VALUE  = 32'shFFFF_FFFF;
  localparam rpn_pkg::value_t NEG_ONE_HALF_3 = 32'shFFFE_8000;  // -1.5
  localparam rpn_pkg::value_t TWO_AND_HALF   = 32'sh0002_8000;  // 2.5

  // shadow stack and queue of result items still to come
  class calc_scoreboard;
    rpn_pkg::value_t    shadow_stack[rpn_pkg::STACK_ENTRIES];
    int unsigned        depth;
    int unsigned        deepest;
    rpn_pkg::out_item_t pending_results[$];
    int unsigned        failures;
    int unsigned        instructions;
    int unsigned        results_seen;
    int unsigned        status_hits[4];

    function new();
      depth = 0;
      deepest = 0;
      failures = 0;
      instructions = 0;
      results_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function rpn_pkg::value_t top_now();
      return (depth > 0) ? shadow_stack[depth - 1] : '0;
    endfunction

    function logic [63:0] magnitude_of(rpn_pkg::value_t v);
      logic signed [63:0] w;
      w = v;
      return (w < 0) ? -w : w;
    endfunction

    // sign onto a magnitude, clamped to the value range
    function rpn_pkg::value_t apply_sign(logic neg, logic [63:0] m);
      logic [63:0] limit;
      limit = magnitude_of(neg ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX);
      if (m > limit) return neg ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
      return neg ? rpn_pkg::value_t'(-m) : rpn_pkg::value_t'(m);
    endfunction

    function rpn_pkg::value_t fit_value(logic signed [63:0] w);
      if (w > longint'(rpn_pkg::VAL_MAX)) return rpn_pkg::VAL_MAX;
      if (w < longint'(rpn_pkg::VAL_MIN)) return rpn_pkg::VAL_MIN;
      return rpn_pkg::value_t'(w);
    endfunction

    // two-operand result, a below b on top
    function rpn_pkg::value_t combine(logic [3:0] mode, rpn_pkg::value_t a,
                                      rpn_pkg::value_t b);
      rpn_pkg::value_t r;
      logic            neg;
      r = '0;
      neg = a[rpn_pkg::VALUE_BITS-1] ^ b[rpn_pkg::VALUE_BITS-1];
      case (mode)
        rpn_pkg::MODE_ADD: r = fit_value(longint'(a) + longint'(b));
        rpn_pkg::MODE_SUB: r = fit_value(longint'(a) - longint'(b));
        rpn_pkg::MODE_MUL:
          r = apply_sign(neg, (magnitude_of(a) * magnitude_of(b)) >> rpn_pkg::FRAC_BITS);
        rpn_pkg::MODE_DIV:
          r = apply_sign(neg, (magnitude_of(a) << rpn_pkg::FRAC_BITS) / magnitude_of(b));
        rpn_pkg::MODE_EQ:  r = (a == b) ? rpn_pkg::ONE_VALUE : '0;
        rpn_pkg::MODE_NE:  r = (a != b) ? rpn_pkg::ONE_VALUE : '0;
        rpn_pkg::MODE_AND: r = (a != 0 && b != 0) ? rpn_pkg::ONE_VALUE : '0;
        rpn_pkg::MODE_OR:  r = (a != 0 || b != 0) ? rpn_pkg::ONE_VALUE : '0;
        rpn_pkg::MODE_GT:  r = (a > b) ? rpn_pkg::ONE_VALUE : '0;
        rpn_pkg::MODE_GE:  r = (a >= b) ? rpn_pkg::ONE_VALUE : '0;
        rpn_pkg::MODE_LT:  r = (a < b) ? rpn_pkg::ONE_VALUE : '0;
        rpn_pkg::MODE_LE:  r = (a <= b) ? rpn_pkg::ONE_VALUE : '0;
        default:           r = '0;
      endcase
      return r;
    endfunction

    // run one accepted instruction on the shadow stack
    function void note_instruction(rpn_pkg::in_item_t item);
      rpn_pkg::out_item_t want;
      rpn_pkg::value_t    a;
      rpn_pkg::value_t    b;
      rpn_pkg::status_t   st;
      st = rpn_pkg::ST_OK;
      instructions++;
      case (item.mode)
        rpn_pkg::MODE_PUSH: begin
          if (depth >= rpn_pkg::STACK_ENTRIES) begin
            st = rpn_pkg::ST_OVER;
          end else begin
            shadow_stack[depth] = item.operand_value;
            depth++;
          end
        end
        rpn_pkg::MODE_NOT: begin
          if (depth < 1) st = rpn_pkg::ST_UNDER;
          else shadow_stack[depth - 1] =
            (shadow_stack[depth - 1] == 0) ? rpn_pkg::ONE_VALUE : '0;
        end
        MODE_SPARE_LO, MODE_SPARE_HI: ;
        default: begin
          if (depth < 2) begin
            st = rpn_pkg::ST_UNDER;
          end else begin
            a = shadow_stack[depth - 2];
            b = shadow_stack[depth - 1];
            if (item.mode == rpn_pkg::MODE_DIV && b == 0) begin
              st = rpn_pkg::ST_DIVZ;
              shadow_stack[depth - 2] = (a < 0) ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
            end else begin
              shadow_stack[depth - 2] = combine(item.mode, a, b);
            end
            depth--;
          end
        end
      endcase
      if (depth > deepest) deepest = depth;
      status_hits[st]++;
      want.top_value   = top_now();
      want.stack_depth = 8'(depth);
      want.status      = st;
      pending_results.push_back(want);
    endfunction

    // compare a result item with the oldest prediction
    function void check_result(rpn_pkg::out_item_t got);
      rpn_pkg::out_item_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with none pending: top_value %h, stack_depth %0d, status %0d",
               got.top_value, got.stack_depth, got.status);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (got.top_value !== want.top_value) begin
        $error("top_value mismatch: expected %h, got %h", want.top_value, got.top_value);
        failures++;
      end
      if (got.stack_depth !== want.stack_depth) begin
        $error("stack_depth mismatch: expected %0d, got %0d", want.stack_depth,
               got.stack_depth);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  rpn_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rpn_pkg::out_item_t out_data;

  int          cycle_count = 0;
  int unsigned send_calm_left = 0;

  calc_scoreboard calc_board = new();

  rpn_stack_calculator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) calc_board.check_result(out_data);
  end

  // backpressure: short stalls mostly, some long ones, now and then a calm stretch
  initial begin
    int run;
    @(posedge clk);
    forever begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 49) == 0) run = $urandom_range(100, 400);
      else run = $urandom_range(1, 6);
      repeat (run) @(posedge clk);
      out_stall <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      repeat (run) @(posedge clk);
    end
  end

  // idle cycles ahead of the next item
  function automatic int pick_send_gap();
    int unsigned r;
    if (send_calm_left > 0) begin
      send_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      send_calm_left = $urandom_range(50, 200);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // operand mix: small integers and fractions, zero, one, the top again, extremes
  function automatic rpn_pkg::value_t random_operand();
    int unsigned pick;
    int          k;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      k = int'($urandom_range(0, 20)) - 10;
      return rpn_pkg::value_t'(k <<< rpn_pkg::FRAC_BITS);
    end
    if (pick < 50)
      return rpn_pkg::value_t'(int'($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
    if (pick < 60) return '0;
    if (pick < 68) return rpn_pkg::ONE_VALUE;
    if (pick < 78) return calc_board.top_now();
    if (pick < 84) begin
      case ($urandom_range(0, 3))
        0: return rpn_pkg::VAL_MAX;
        1: return rpn_pkg::VAL_MIN;
        2: return LSB_VALUE;
        default: return NEG_LSB_VALUE;
      endcase
    end
    return rpn_pkg::value_t'($urandom);
  endfunction

  // offer one instruction and hold it until taken
  task automatic send_instruction(input logic [3:0] mode, input rpn_pkg::value_t operand);
    rpn_pkg::in_item_t item;
    int                gap;
    item.mode = mode;
    item.operand_value = operand;
    gap = pick_send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    calc_board.note_instruction(item);
  endtask

  initial begin
    logic [3:0]      mode;
    rpn_pkg::value_t operand;
    int unsigned     counted;
    int unsigned     push_pct;
    int unsigned     spill;
    int unsigned     step;
    logic            filling;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: underflow on an empty stack and with one entry
    send_instruction(rpn_pkg::MODE_ADD, '0);
    send_instruction(rpn_pkg::MODE_NOT, '0);
    send_instruction(rpn_pkg::MODE_PUSH, rpn_pkg::VAL_MAX);
    send_instruction(rpn_pkg::MODE_SUB, '0);
    // saturation of add, sub and mul
    send_instruction(rpn_pkg::MODE_PUSH, rpn_pkg::VAL_MAX);
    send_instruction(rpn_pkg::MODE_ADD, '0);
    send_instruction(rpn_pkg::MODE_PUSH, rpn_pkg::VAL_MIN);
    send_instruction(rpn_pkg::MODE_SUB, '0);
    send_instruction(rpn_pkg::MODE_PUSH, rpn_pkg::VAL_MIN);
    send_instruction(rpn_pkg::MODE_MUL, '0);
    // divide by zero with negative, then positive dividend; not both ways
    send_instruction(rpn_pkg::MODE_PUSH, '0);
    send_instruction(rpn_pkg::MODE_DIV, rpn_pkg::VAL_MAX);
    send_instruction(rpn_pkg::MODE_NOT, '0);
    send_instruction(rpn_pkg::MODE_NOT, '0);
    send_instruction(rpn_pkg::MODE_PUSH, '0);
    send_instruction(rpn_pkg::MODE_DIV, '0);
    // quotient too large
    send_instruction(rpn_pkg::MODE_PUSH, LSB_VALUE);
    send_instruction(rpn_pkg::MODE_DIV, '0);
    // compare and logic operations
    send_instruction(rpn_pkg::MODE_PUSH, NEG_ONE_HALF_3);
    send_instruction(rpn_pkg::MODE_GT, '0);
    send_instruction(rpn_pkg::MODE_PUSH, '0);
    send_instruction(rpn_pkg::MODE_AND, '0);
    send_instruction(rpn_pkg::MODE_PUSH, NEG_LSB_VALUE);
    send_instruction(rpn_pkg::MODE_OR, '0);
    send_instruction(rpn_pkg::MODE_PUSH, TWO_AND_HALF);
    send_instruction(rpn_pkg::MODE_LE, '0);
    send_instruction(rpn_pkg::MODE_PUSH, rpn_pkg::ONE_VALUE);
    send_instruction(rpn_pkg::MODE_EQ, '0);
    send_instruction(rpn_pkg::MODE_PUSH, NEG_ONE_HALF_3);
    send_instruction(rpn_pkg::MODE_GE, '0);
    send_instruction(rpn_pkg::MODE_PUSH, '0);
    send_instruction(rpn_pkg::MODE_LT, '0);
    send_instruction(rpn_pkg::MODE_PUSH, rpn_pkg::ONE_VALUE);
    send_instruction(rpn_pkg::MODE_NE, rpn_pkg::VAL_MIN);
    send_instruction(MODE_SPARE_LO, rpn_pkg::VAL_MIN);
    send_instruction(MODE_SPARE_HI, rpn_pkg::VAL_MAX);

    // random: mostly well-formed programs, some noise, bursts that fill the stack
    counted = 0;
    step = 0;
    filling = 1'b0;
    spill = 0;
    push_pct = 50;
    while (counted < RANDOM_ITEMS) begin
      if (step % 64 == 0) push_pct = 25 * $urandom_range(1, 3);
      step++;
      if (!filling && $urandom_range(0, 399) == 0) begin
        filling = 1'b1;
        spill = $urandom_range(1, 3);
      end
      operand = random_operand();
      if (filling) begin
        mode = rpn_pkg::MODE_PUSH;
        if (calc_board.depth >= rpn_pkg::STACK_ENTRIES) begin
          spill--;
          if (spill == 0) filling = 1'b0;
        end
      end else if ($urandom_range(0, 19) == 0) begin
        mode = 4'($urandom);
        if ($urandom_range(0, 1) == 0) operand = rpn_pkg::value_t'($urandom);
      end else if (calc_board.depth < 2 ||
                   (calc_board.depth < rpn_pkg::STACK_ENTRIES &&
                    $urandom_range(0, 99) < push_pct)) begin
        mode = rpn_pkg::MODE_PUSH;
      end else begin
        mode = 4'($urandom_range(rpn_pkg::MODE_ADD, rpn_pkg::MODE_NOT));
      end
      send_instruction(mode, operand);
      if (mode != MODE_SPARE_LO && mode != MODE_SPARE_HI) counted++;
    end
    in_valid <= 1'b0;

    // drain and let the block settle
    while (calc_board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d instructions, %0d result items checked, stack reached depth %0d",
             calc_board.instructions, calc_board.results_seen, calc_board.deepest);
    $display("statuses seen: %0d ok, %0d underflow, %0d overflow, %0d divide by zero",
             calc_board.status_hits[rpn_pkg::ST_OK], calc_board.status_hits[rpn_pkg::ST_UNDER],
             calc_board.status_hits[rpn_pkg::ST_OVER], calc_board.status_hits[rpn_pkg::ST_DIVZ]);
    if (calc_board.failures == 0 && calc_board.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_ctrl.sv
hw/rtl/rpn_dpath.sv
hw/rtl/rpn_stack_calculator.sv
hw/rtl/rpn_checker.sv
bench/tb_rpn_stack_calculator.sv
